### rtl/core/bezier_spline_path_evaluator_top_macros.svh
// Assertion helpers for the spline path evaluator.
// Each one is clocked on clk_i and is off while rst_ni is low.
`ifndef BEZIER_SPLINE_PATH_EVALUATOR_TOP_MACROS_SVH
`define BEZIER_SPLINE_PATH_EVALUATOR_TOP_MACROS_SVH

// When ante holds, cons must hold in the same cycle.
`define BSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define BSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bsp_pkg.sv
package bsp_pkg;

  localparam int MAX_POINTS = 16;
  localparam int SAMPLES    = 100;
  localparam int FRAC_BITS  = 16;

  localparam int WORDS     = 6;
  localparam int RAM_DEPTH = MAX_POINTS * WORDS;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int PT_W      = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);

  localparam int T_W = FRAC_BITS + 1;
  localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;

  // curve values stay inside the hull of p, p+h, q-g, q
  localparam int VW = 34;
  localparam int DW = VW + 1;
  localparam int PW = DW + T_W + 1;

  localparam int K_W = $clog2(SAMPLES);
  localparam int R_W = $clog2(SAMPLES) + 1;
  localparam logic [T_W-1:0] T_STEP_Q = T_W'((2 ** FRAC_BITS) / SAMPLES);
  localparam logic [R_W-1:0] T_STEP_R = R_W'((2 ** FRAC_BITS) % SAMPLES);

  localparam int ACC_W = 48;

  localparam int DIV_N_W   = 32 + FRAC_BITS;
  localparam int DIV_D_W   = 32;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_RECOMP = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // de Casteljau schedule on a 4-entry rotating line:
  // lerp lerp lerp skip lerp lerp skip skip lerp, result in the last slot
  localparam int N_OPS = 9;

  function automatic logic op_is_lerp(input logic [3:0] step);
    logic r;
    case (step)
      4'd3, 4'd6, 4'd7: r = 1'b0;
      default:          r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] word_addr(input logic [PT_W-1:0] pt,
                                                  input logic [2:0] word);
    return ADDR_W'(pt) * ADDR_W'(WORDS) + ADDR_W'(word);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [VW-1:0] v);
    logic [31:0] r;
    if ((&v[VW-1:31]) || !(|v[VW-1:31])) begin
      r = v[31:0];
    end else if (v[VW-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

### rtl/core/bsp_if.sv
interface bsp_req_if;
  import bsp_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  point_index;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] handle_x;
  logic [31:0] handle_y;
  logic [31:0] handle_z;
  logic [31:0] path_length;

  modport source (output valid, req_type, point_index, pos_x, pos_y, pos_z,
                  handle_x, handle_y, handle_z, path_length, input ready);
  modport sink (input valid, req_type, point_index, pos_x, pos_y, pos_z,
                handle_x, handle_y, handle_z, path_length, output ready);
endinterface

interface bsp_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] path_total;

  modport source (output valid, result_kind, out_x, out_y, out_z, path_total,
                  input ready);
  modport sink (input valid, result_kind, out_x, out_y, out_z, path_total,
                output ready);
endinterface

interface bsp_cfg_if;
  import bsp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/bsp_ram.sv
module bsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/core/bsp_lerp.sv
// Shared lerp unit: registered product, add on the next cycle.
module bsp_lerp import bsp_pkg::*; (
  input  logic                  clk_i,
  input  logic signed [VW-1:0]  a_i,
  input  logic signed [VW-1:0]  b_i,
  input  logic [T_W-1:0]        t_i,
  output logic signed [VW-1:0]  y_o
);

  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [VW-1:0] a_q;

  assign diff   = DW'(b_i) - DW'(a_i);
  assign prod_d = PW'(diff) * PW'($signed({1'b0, t_i}));

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    prod_q <= prod_d;
  end

  // arithmetic shift is the floor of the scaled product
  assign y_o = a_q + VW'(prod_q >>> FRAC_BITS);

endmodule

### rtl/core/bsp_div.sv
// Restoring divider, one quotient bit per cycle.
module bsp_div import bsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] num_i,
  input  logic [DIV_D_W-1:0] den_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quo_o,
  output logic [DIV_D_W-1:0] rem_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_N_W-1:0]   quo_q;
  logic [DIV_D_W-1:0]   rem_q, den_q;
  logic [DIV_D_W:0]     trial, diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

### rtl/core/bezier_spline_path_evaluator_top.sv
// Cubic Bezier spline path evaluator. Holds up to 16 control points (position
// and handle, signed Q16.16) in a 96-word RAM and serves one request at a time
// on req_i, answering each with exactly one response on rsp_o. A write stores
// one point and marks the segment lengths stale. A recompute
// samples each segment at 99 values of t with de Casteljau and sums per-axis
// absolute steps; each sample runs three axes (RAM reads, six passes through
// the one shared lerp multiplier, three rotations, one finish and one step),
// then advances t. A query wraps the distance by the path total with a divide,
// walks the segments, divides again for t and evaluates the curve once,
// skipping the t divide when the segment has zero length or the distance runs
// past the end. Stale lengths count as 1.0 per segment; a distance past the
// end lands on the last segment at t = 1. req_i.ready is low from acceptance
// until the response is in the output register; that register lets one
// response wait while the next request is taken. Config writes (loop enable at
// index 0, point_count at index 1) are always accepted and must only come while
// the block is idle. Unwritten points read undefined.
`include "bezier_spline_path_evaluator_top_macros.svh"

module bezier_spline_path_evaluator_top import bsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  bsp_cfg_if.sink  cfg_i,
  bsp_req_if.sink  req_i,
  bsp_rsp_if.source rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_PLD, S_PFIN, S_LOAD, S_OPS, S_ADD,
    S_AXIS, S_SAMP, S_MOD, S_WALK, S_TDIV, S_DONE
  } state_e;

  // control
  state_e          state_q, state_d;
  logic            closed_q, closed_d;
  logic [4:0]      count_q, count_d;
  logic            lvalid_q, lvalid_d;
  logic [31:0]     total_q, total_d;
  logic            out_valid_q, out_valid_d;

  // request and work registers
  req_e                kind_q, kind_d;
  logic [3:0]          idx_q, idx_d;
  logic [31:0]         wr_q [WORDS];
  logic [31:0]         wr_d [WORDS];
  logic [31:0]         rem_q, rem_d;
  logic [PT_W-1:0]     seg_q, seg_d;
  logic [1:0]          axis_q, axis_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [K_W-1:0]      k_q, k_d;
  logic [T_W-1:0]      t_q, t_d;
  logic [R_W-1:0]      tr_q, tr_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [31:0]         tot_q, tot_d;
  logic signed [VW-1:0] v_q [4];
  logic signed [VW-1:0] v_d [4];
  logic signed [VW-1:0] prev_q [3];
  logic signed [VW-1:0] prev_d [3];
  logic [31:0]         res_q [3];
  logic [31:0]         res_d [3];
  logic [31:0]         seg_len_q [MAX_POINTS];
  logic [31:0]         seg_len_d [MAX_POINTS];
  logic [1:0]          out_kind_q, out_kind_d;
  logic [31:0]         out_x_q, out_x_d, out_y_q, out_y_d, out_z_q, out_z_d;
  logic [31:0]         out_tot_q, out_tot_d;

  // point store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [31:0]       ram_wdata, ram_rdata;
  logic signed [VW-1:0] rd_ext;

  // shared units
  logic signed [VW-1:0] lerp_y;
  logic                 div_start, div_done;
  logic [DIV_N_W-1:0]   div_num, div_quo;
  logic [DIV_D_W-1:0]   div_den, div_rem;

  // geometry
  logic [CNT_W-1:0] n_pts, n_segs, nxt;
  logic [PT_W-1:0]  j_pt;
  logic             last_seg;
  logic             wr_ok;
  logic [31:0]      qtotal, seg_l, samp_len;
  logic [32:0]      tot_sum;
  logic signed [VW:0] step_diff;
  logic [VW:0]      step_abs;
  logic [R_W-1:0]   r_sum;

  assign n_pts    = (CNT_W'(count_q) > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                           : CNT_W'(count_q);
  assign n_segs   = (n_pts < CNT_W'(2)) ? '0 : n_pts - 1'b1 + CNT_W'(closed_q);
  assign nxt      = CNT_W'(seg_q) + 1'b1;
  assign j_pt     = (nxt >= n_pts) ? '0 : PT_W'(nxt);
  assign last_seg = CNT_W'(seg_q) == n_segs - 1'b1;
  assign wr_ok    = CNT_W'(idx_q) < CNT_W'(MAX_POINTS);
  assign rd_ext   = VW'($signed(ram_rdata));

  assign qtotal   = lvalid_q ? total_q : (32'(n_segs) << FRAC_BITS);
  assign seg_l    = lvalid_q ? seg_len_q[seg_q] : 32'(ONE);
  assign samp_len = (acc_q > ACC_W'(32'hffff_ffff)) ? 32'hffff_ffff : acc_q[31:0];
  assign tot_sum  = {1'b0, tot_q} + {1'b0, samp_len};
  assign step_diff = (VW+1)'(v_q[3]) - (VW+1)'(prev_q[axis_q]);
  assign step_abs  = step_diff[VW] ? $unsigned(-step_diff) : $unsigned(step_diff);
  assign r_sum     = tr_q + T_STEP_R;

  // RAM port: write sweep, point 0 load, or the four words of one axis
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = wr_q[cnt_q[2:0]];
    case (state_q)
      S_WRITE: begin
        ram_we   = wr_ok;
        ram_addr = word_addr(PT_W'(idx_q), cnt_q[2:0]);
      end
      S_PLD: begin
        ram_addr = ADDR_W'(cnt_q);
      end
      S_LOAD: begin
        case (cnt_q)
          4'd0:    ram_addr = word_addr(seg_q, {1'b0, axis_q});
          4'd1:    ram_addr = word_addr(seg_q, 3'({1'b0, axis_q}) + 3'd3);
          4'd2:    ram_addr = word_addr(j_pt, {1'b0, axis_q});
          default: ram_addr = word_addr(j_pt, 3'({1'b0, axis_q}) + 3'd3);
        endcase
      end
      default: ram_addr = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    closed_d    = closed_q;
    count_d     = count_q;
    lvalid_d    = lvalid_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    wr_d        = wr_q;
    rem_d       = rem_q;
    seg_d       = seg_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    t_d         = t_q;
    tr_d        = tr_q;
    acc_d       = acc_q;
    tot_d       = tot_q;
    v_d         = v_q;
    prev_d      = prev_q;
    res_d       = res_q;
    seg_len_d   = seg_len_q;
    out_kind_d  = out_kind_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_z_d     = out_z_q;
    out_tot_d   = out_tot_q;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    // config: either register makes the lengths stale
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LOOP_EN: begin
          closed_d = cfg_i.data[0];
          lvalid_d = 1'b0;
        end
        CFG_POINT_COUNT: begin
          count_d  = cfg_i.data[4:0];
          lvalid_d = 1'b0;
        end
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d   = req_e'(req_i.req_type);
          idx_d    = req_i.point_index;
          wr_d[0]  = req_i.pos_x;
          wr_d[1]  = req_i.pos_y;
          wr_d[2]  = req_i.pos_z;
          wr_d[3]  = req_i.handle_x;
          wr_d[4]  = req_i.handle_y;
          wr_d[5]  = req_i.handle_z;
          res_d[0] = '0;
          res_d[1] = '0;
          res_d[2] = '0;
          cnt_d    = '0;
          axis_d   = '0;
          seg_d    = '0;
          case (req_e'(req_i.req_type))
            REQ_WRITE:  state_d = S_WRITE;
            REQ_RECOMP: state_d = S_PLD;
            REQ_QUERY: begin
              if (n_pts == '0) begin
                state_d = S_DONE;
              end else if (n_pts == CNT_W'(1)) begin
                state_d = S_PLD;
              end else if (qtotal != '0) begin
                div_start = 1'b1;
                div_num   = DIV_N_W'(req_i.path_length);
                div_den   = qtotal;
                state_d   = S_MOD;
              end else begin
                rem_d   = req_i.path_length;
                state_d = S_WALK;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_WRITE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'(WORDS - 1)) begin
          if (wr_ok) begin
            lvalid_d = 1'b0;
          end
          state_d = S_DONE;
        end
      end

      // point 0 position: start of the recompute walk, or the lone-point answer
      S_PLD: begin
        if (cnt_q != '0) begin
          prev_d[2'(cnt_q - 1'b1)] = rd_ext;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd3) begin
          state_d = S_PFIN;
        end
      end

      S_PFIN: begin
        if (kind_q == REQ_QUERY) begin
          res_d[0] = prev_q[0][31:0];
          res_d[1] = prev_q[1][31:0];
          res_d[2] = prev_q[2][31:0];
          state_d  = S_DONE;
        end else if (n_segs == '0) begin
          total_d  = '0;
          lvalid_d = 1'b1;
          state_d  = S_DONE;
        end else begin
          seg_d   = '0;
          k_d     = K_W'(1);
          t_d     = T_STEP_Q;
          tr_d    = T_STEP_R;
          acc_d   = '0;
          tot_d   = '0;
          axis_d  = '0;
          cnt_d   = '0;
          state_d = S_LOAD;
        end
      end

      // control points c0 = p, c1 = p + h, c3 = q, c2 = q - g
      S_LOAD: begin
        case (cnt_q)
          4'd1:    v_d[0] = rd_ext;
          4'd2:    v_d[1] = v_q[0] + rd_ext;
          4'd3:    v_d[3] = rd_ext;
          4'd4:    v_d[2] = v_q[3] - rd_ext;
          default: ;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd4) begin
          cnt_d   = '0;
          state_d = S_OPS;
        end
      end

      S_OPS: begin
        if (cnt_q == 4'(N_OPS)) begin
          state_d = S_AXIS;
        end else if (op_is_lerp(cnt_q)) begin
          state_d = S_ADD;
        end else begin
          v_d[0] = v_q[1];
          v_d[1] = v_q[2];
          v_d[2] = v_q[3];
          v_d[3] = v_q[0];
          cnt_d  = cnt_q + 1'b1;
        end
      end

      S_ADD: begin
        v_d[0]  = v_q[1];
        v_d[1]  = v_q[2];
        v_d[2]  = v_q[3];
        v_d[3]  = lerp_y;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_OPS;
      end

      S_AXIS: begin
        if (kind_q == REQ_QUERY) begin
          res_d[axis_q] = sat32(v_q[3]);
        end else begin
          acc_d          = acc_q + ACC_W'(step_abs);
          prev_d[axis_q] = v_q[3];
        end
        cnt_d = '0;
        if (axis_q == 2'd2) begin
          axis_d  = '0;
          state_d = (kind_q == REQ_QUERY) ? S_DONE : S_SAMP;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_LOAD;
        end
      end

      // next sample, next segment or finish: t = floor(k * ONE / SAMPLES) kept as quotient and remainder
      S_SAMP: begin
        state_d = S_LOAD;
        if (k_q == K_W'(SAMPLES - 1)) begin
          seg_len_d[seg_q] = samp_len;
          acc_d            = '0;
          if (last_seg) begin
            total_d  = tot_sum[32] ? 32'hffff_ffff : tot_sum[31:0];
            lvalid_d = 1'b1;
            state_d  = S_DONE;
          end else begin
            tot_d = tot_sum[32] ? 32'hffff_ffff : tot_sum[31:0];
            seg_d = seg_q + 1'b1;
            k_d   = K_W'(1);
            t_d   = T_STEP_Q;
            tr_d  = T_STEP_R;
          end
        end else begin
          k_d = k_q + 1'b1;
          if (r_sum >= R_W'(SAMPLES)) begin
            tr_d = r_sum - R_W'(SAMPLES);
            t_d  = t_q + T_STEP_Q + 1'b1;
          end else begin
            tr_d = r_sum;
            t_d  = t_q + T_STEP_Q;
          end
        end
      end

      S_MOD: begin
        if (div_done) begin
          rem_d   = div_rem;
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        if (rem_q <= seg_l) begin
          if (seg_l == '0) begin
            t_d     = '0;
            state_d = S_LOAD;
          end else begin
            div_start = 1'b1;
            div_num   = {rem_q, FRAC_BITS'(0)};
            div_den   = seg_l;
            state_d   = S_TDIV;
          end
        end else begin
          rem_d = rem_q - seg_l;
          if (last_seg) begin
            // ran past the end: last segment at t = 1
            t_d     = ONE;
            state_d = S_LOAD;
          end else begin
            seg_d = seg_q + 1'b1;
          end
        end
      end

      S_TDIV: begin
        if (div_done) begin
          t_d     = div_quo[T_W-1:0];
          state_d = S_LOAD;
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = (kind_q == REQ_NONE) ? REQ_WRITE : kind_q;
          out_x_d     = res_q[0];
          out_y_d     = res_q[1];
          out_z_d     = res_q[2];
          out_tot_d   = total_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      closed_q    <= 1'b0;
      count_q     <= '0;
      lvalid_q    <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      axis_q      <= '0;
      seg_q       <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      closed_q    <= closed_d;
      count_q     <= count_d;
      lvalid_q    <= lvalid_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      seg_q       <= seg_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    idx_q      <= idx_d;
    wr_q       <= wr_d;
    rem_q      <= rem_d;
    t_q        <= t_d;
    tr_q       <= tr_d;
    acc_q      <= acc_d;
    tot_q      <= tot_d;
    v_q        <= v_d;
    prev_q     <= prev_d;
    res_q      <= res_d;
    seg_len_q  <= seg_len_d;
    out_kind_q <= out_kind_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_z_q    <= out_z_d;
    out_tot_q  <= out_tot_d;
  end

  bsp_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_points (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  bsp_lerp u_lerp (
    .clk_i (clk_i),
    .a_i   (v_q[0]),
    .b_i   (v_q[1]),
    .t_i   (t_q),
    .y_o   (lerp_y)
  );

  bsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  assign cfg_i.ready       = 1'b1;
  assign req_i.ready       = state_q == S_IDLE;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result_kind = out_kind_q;
  assign rsp_o.out_x       = out_x_q;
  assign rsp_o.out_y       = out_y_q;
  assign rsp_o.out_z       = out_z_q;
  assign rsp_o.path_total  = out_tot_q;

  // a response only appears when a request has just finished
  `BSP_ASSERT_SAME(a_rsp_from_done, $rose(rsp_o.valid), $past(state_q == S_DONE), "response without finished request")
  // a taken request leaves idle at once
  `BSP_ASSERT_NEXT(a_req_leaves_idle, req_i.valid && req_i.ready, state_q != S_IDLE, "request taken but block still idle")
  // curve evaluation only on an existing segment
  `BSP_ASSERT_SAME(a_seg_in_range, state_q == S_LOAD, CNT_W'(seg_q) < n_segs, "segment out of range")
  // t never exceeds one
  `BSP_ASSERT_SAME(a_t_le_one, state_q == S_ADD, t_q <= ONE, "t above one")

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bsp_pkg::*;

  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  idx;
    logic [31:0] px, py, pz, hx, hy, hz;
    logic [31:0] plen;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] x, y, z, total;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  bsp_cfg_if cfg_ch ();
  bsp_req_if req_ch ();
  bsp_rsp_if rsp_ch ();

  bezier_spline_path_evaluator_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .req_i (req_ch.sink),
    .rsp_o (rsp_ch.source)
  );

  // Shadow copy of the block state
  longint pt_word[RAM_DEPTH];
  longint seg_len[MAX_POINTS];
  bit     lens_ok;
  longint path_sum;
  bit     loop_on;
  int     pt_count;

  rsp_t   pending_rsp[$];
  int     fail_cnt = 0;
  bit     calm = 1'b0;  // no idling on either side while set
  longint cyc = 0;

  function automatic longint lerp_q(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> FRAC_BITS);
  endfunction

  function automatic void curve_at(input int seg, input longint t, input int n,
                                   output longint o[3]);
    int nxt;
    longint c0, c1, c2, c3, d0, d1, d2, e0, e1;
    nxt = (seg + 1 >= n) ? 0 : seg + 1;
    for (int a = 0; a < 3; a++) begin
      c0 = pt_word[seg*WORDS + a];
      c1 = c0 + pt_word[seg*WORDS + 3 + a];
      c3 = pt_word[nxt*WORDS + a];
      c2 = c3 - pt_word[nxt*WORDS + 3 + a];
      d0 = lerp_q(c0, c1, t);
      d1 = lerp_q(c1, c2, t);
      d2 = lerp_q(c2, c3, t);
      e0 = lerp_q(d0, d1, t);
      e1 = lerp_q(d1, d2, t);
      o[a] = lerp_q(e0, e1, t);
    end
  endfunction

  function automatic int pts_used();
    return pt_count > MAX_POINTS ? MAX_POINTS : pt_count;
  endfunction

  function automatic int segs_of(int n);
    return n < 2 ? 0 : n - 1 + int'(loop_on);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Sample every segment and sum per-axis absolute steps
  function automatic void measure_path();
    int n, ns;
    longint prv[3], cur[3], acc, tot, t;
    n = pts_used();
    ns = segs_of(n);
    tot = 0;
    for (int a = 0; a < 3; a++) prv[a] = pt_word[a];
    for (int s = 0; s < ns; s++) begin
      acc = 0;
      for (int k = 1; k < SAMPLES; k++) begin
        t = (longint'(k) << FRAC_BITS) / SAMPLES;
        curve_at(s, t, n, cur);
        for (int a = 0; a < 3; a++) begin
          acc += (cur[a] < prv[a]) ? prv[a] - cur[a] : cur[a] - prv[a];
          prv[a] = cur[a];
        end
      end
      seg_len[s] = acc > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : acc;
      tot += seg_len[s];
      if (tot > 64'hFFFF_FFFF) tot = 64'hFFFF_FFFF;
    end
    path_sum = tot;
    lens_ok = 1'b1;
  endfunction

  function automatic void locate(input longint span, output longint o[3]);
    int n, ns, seg;
    longint total, t, l;
    n = pts_used();
    if (n == 0) begin
      o = '{0, 0, 0};
      return;
    end
    if (n == 1) begin
      o = '{pt_word[0], pt_word[1], pt_word[2]};
      return;
    end
    ns = segs_of(n);
    total = lens_ok ? path_sum : longint'(ns) << FRAC_BITS;
    if (total != 0) span = span % total;
    seg = ns - 1;
    t = longint'(ONE);
    for (int s = 0; s < ns; s++) begin
      l = lens_ok ? seg_len[s] : longint'(ONE);
      if (span <= l) begin
        seg = s;
        t = (l == 0) ? 0 : (span << FRAC_BITS) / l;
        break;
      end
      span -= l;
    end
    curve_at(seg, t, n, o);
  endfunction

  function automatic rsp_t serve_req(req_t r);
    rsp_t   e;
    longint p[3];
    p = '{0, 0, 0};
    case (req_e'(r.kind))
      REQ_WRITE: begin
        pt_word[r.idx*WORDS + 0] = longint'(signed'(r.px));
        pt_word[r.idx*WORDS + 1] = longint'(signed'(r.py));
        pt_word[r.idx*WORDS + 2] = longint'(signed'(r.pz));
        pt_word[r.idx*WORDS + 3] = longint'(signed'(r.hx));
        pt_word[r.idx*WORDS + 4] = longint'(signed'(r.hy));
        pt_word[r.idx*WORDS + 5] = longint'(signed'(r.hz));
        lens_ok = 1'b0;
      end
      REQ_RECOMP: measure_path();
      REQ_QUERY:  locate(longint'(r.plen), p);
      default: ;
    endcase
    e.kind  = (req_e'(r.kind) == REQ_NONE) ? REQ_WRITE : r.kind;
    e.x     = (req_e'(r.kind) == REQ_QUERY) ? clamp32(p[0]) : '0;
    e.y     = (req_e'(r.kind) == REQ_QUERY) ? clamp32(p[1]) : '0;
    e.z     = (req_e'(r.kind) == REQ_QUERY) ? clamp32(p[2]) : '0;
    e.total = path_sum[31:0];
    return e;
  endfunction

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_LOOP_EN;
    cfg_ch.data  = '0;
    req_ch.valid = 1'b0;
    {req_ch.req_type, req_ch.point_index, req_ch.pos_x, req_ch.pos_y, req_ch.pos_z,
     req_ch.handle_x, req_ch.handle_y, req_ch.handle_z, req_ch.path_length} = '0;
    rsp_ch.ready = 1'b0;
  end

  // Response side backpressure
  always @(posedge clk_i) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= 20);
  end

  // Response check; fields are stable at the falling edge before acceptance
  always @(negedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response kind=%0d", rsp_ch.result_kind);
        fail_cnt++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_ch.result_kind !== e.kind) begin
          $error("result_kind exp %0d got %0d", e.kind, rsp_ch.result_kind);
          fail_cnt++;
        end
        if (rsp_ch.out_x !== e.x) begin
          $error("out_x exp %h got %h", e.x, rsp_ch.out_x);
          fail_cnt++;
        end
        if (rsp_ch.out_y !== e.y) begin
          $error("out_y exp %h got %h", e.y, rsp_ch.out_y);
          fail_cnt++;
        end
        if (rsp_ch.out_z !== e.z) begin
          $error("out_z exp %h got %h", e.z, rsp_ch.out_z);
          fail_cnt++;
        end
        if (rsp_ch.path_total !== e.total) begin
          $error("path_total exp %h got %h", e.total, rsp_ch.path_total);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge that took the request
  task automatic send_req(req_t r);
    if (!calm && $urandom_range(99) < 20) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= r.kind;
    req_ch.point_index <= r.idx;
    req_ch.pos_x       <= r.px;
    req_ch.pos_y       <= r.py;
    req_ch.pos_z       <= r.pz;
    req_ch.handle_x    <= r.hx;
    req_ch.handle_y    <= r.hy;
    req_ch.handle_z    <= r.hz;
    req_ch.path_length <= r.plen;
    do @(negedge clk_i); while (!req_ch.ready);
    @(posedge clk_i);
    pending_rsp = {pending_rsp, serve_req(r)};
  endtask

  // Drop valid and wait until every response is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk_i); while (!cfg_ch.ready);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_LOOP_EN) loop_on = val[0];
    else pt_count = val[4:0];
    lens_ok = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic req_t mk_write(logic [3:0] idx);
    req_t r;
    r      = '0;
    r.kind = REQ_WRITE;
    r.idx  = idx;
    r.px = rand_coord(); r.py = rand_coord(); r.pz = rand_coord();
    r.hx = rand_coord(); r.hy = rand_coord(); r.hz = rand_coord();
    r.plen = $urandom;  // ignored by a write, toggles the lines anyway
    return r;
  endfunction

  function automatic req_t mk_op(req_e k, logic [31:0] d);
    req_t r;
    r      = '0;
    r.kind = k;
    r.plen = d;
    r.idx  = 4'($urandom);
    return r;
  endfunction

  // Empty path, the unused request code, then every point loaded
  task automatic test_empty_and_fill();
    req_t r;
    send_req(mk_op(REQ_QUERY, 32'hffff_ffff));
    send_req(mk_op(REQ_NONE, 32'h1234_5678));
    r = '0; r.kind = REQ_WRITE; r.idx = 4'd0;
    r.px = 32'h7fff_ffff; r.py = 32'h8000_0000; r.pz = '0;
    r.hx = 32'h8000_0000; r.hy = 32'h7fff_ffff; r.hz = 32'hffff_ffff;
    send_req(r);
    for (int i = 1; i < MAX_POINTS; i++) send_req(mk_write(4'(i)));
  endtask

  // One point, stale lengths, overrun, zero and saturated sums
  task automatic test_directed();
    write_cfg(CFG_POINT_COUNT, 32'd1);
    send_req(mk_op(REQ_QUERY, 32'd12345));
    write_cfg(CFG_POINT_COUNT, 32'd2);
    write_cfg(CFG_LOOP_EN, 32'd0);
    send_req(mk_op(REQ_QUERY, 32'd0));
    send_req(mk_op(REQ_QUERY, 32'h0000_8000));
    send_req(mk_op(REQ_QUERY, 32'h0001_0000));
    send_req(mk_op(REQ_RECOMP, 32'd0));
    send_req(mk_op(REQ_QUERY, 32'hffff_ffff));
    send_req(mk_op(REQ_QUERY, 32'd77));
    write_cfg(CFG_LOOP_EN, 32'd1);
    send_req(mk_op(REQ_QUERY, 32'h0001_8000));
    send_req(mk_op(REQ_RECOMP, 32'd0));
    send_req(mk_op(REQ_QUERY, $urandom));
    // fewer than two points on recompute gives a zero total
    write_cfg(CFG_POINT_COUNT, 32'd1);
    send_req(mk_op(REQ_RECOMP, 32'd0));
    send_req(mk_op(REQ_QUERY, 32'd5));
    // full path, closed: the longest recompute
    write_cfg(CFG_POINT_COUNT, 32'd16);
    send_req(mk_op(REQ_QUERY, 32'h000f_ffff));
    send_req(mk_op(REQ_RECOMP, 32'd0));
    send_req(mk_op(REQ_QUERY, 32'hffff_ffff));
    send_req(mk_op(REQ_QUERY, $urandom));
    write_cfg(CFG_LOOP_EN, 32'd0);
    write_cfg(CFG_POINT_COUNT, 32'd0);
    send_req(mk_op(REQ_QUERY, 32'd9));
  endtask

  task automatic test_random();
    int     n;
    int     roll;
    longint d;
    for (int ph = 0; ph < 12; ph++) begin
      roll = $urandom_range(99);
      n = roll < 60 ? $urandom_range(2, 4) : roll < 90 ? $urandom_range(0, 6) : 16;
      write_cfg(CFG_LOOP_EN, $urandom_range(1));
      write_cfg(CFG_POINT_COUNT, n);
      calm = (ph == 3);
      for (int i = 0; i < 145; i++) begin
        if (ph == 6 && i == 70) drain();
        roll = $urandom_range(199);
        if (roll < 80) begin
          send_req(mk_write(4'($urandom)));
        end else if (roll < 84 && (n < 8 || $urandom_range(9) == 0)) begin
          send_req(mk_op(REQ_RECOMP, $urandom));
        end else if (roll < 190) begin
          d = lens_ok ? path_sum : longint'(segs_of(pts_used())) << FRAC_BITS;
          if ($urandom_range(2) == 0 || d == 0)
            send_req(mk_op(REQ_QUERY, $urandom));
          else
            send_req(mk_op(REQ_QUERY, 32'($urandom % (d + 1))));
        end else begin
          send_req(mk_op(REQ_NONE, $urandom));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    lens_ok  = 1'b0;
    path_sum = 0;
    loop_on  = 1'b0;
    pt_count = 0;
    foreach (pt_word[i]) pt_word[i] = 0;
    foreach (seg_len[i]) seg_len[i] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_fill();
    test_directed();
    test_random();

    drain();
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### bezier_spline_path_evaluator_top.f
+incdir+rtl/core
rtl/core/bsp_pkg.sv
rtl/core/bsp_if.sv
rtl/core/bsp_ram.sv
rtl/core/bsp_lerp.sv
rtl/core/bsp_div.sv
rtl/core/bezier_spline_path_evaluator_top.sv
test/tb_top.sv
